### rtl/cst_pkg.sv
// Package with the item types, action codes and cell controls of the cursor sequence table.
package cst_pkg;

  localparam int unsigned DepthDef    = 32;
  localparam int unsigned WordBitsDef = 64;
  localparam int unsigned PosBits     = 11;
  localparam int unsigned CountBits   = 6;
  localparam int unsigned FieldBits   = 64;

  typedef enum logic [2:0] {
    ACT_START   = 3'd0,
    ACT_ADVANCE = 3'd1,
    ACT_INSERT  = 3'd2,
    ACT_ATTACH  = 3'd3,
    ACT_REMOVE  = 3'd4,
    ACT_READ    = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_OPEN  = 2'd1,
    CELL_CLOSE = 2'd2
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e           mode;
    logic [PosBits-1:0]   pos;
  } cell_ctrl_t;

  typedef struct packed {
    logic [2:0]           action;
    logic [FieldBits-1:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic                 refused;
    logic                 has_current;
    logic [FieldBits-1:0] current_word;
    logic [CountBits-1:0] item_count;
  } out_item_t;

endpackage

### rtl/cst_cell.sv
// One storage cell of the list: holds one word and moves it with its neighbors.
module cst_cell #(
  parameter int unsigned WORD_BITS = 64,
  parameter int unsigned INDEX     = 0
) (
  input  logic                 clk_i,
  input  cst_pkg::cell_ctrl_t  ctrl_i,
  input  logic [WORD_BITS-1:0] load_word_i,
  input  logic [WORD_BITS-1:0] left_i,
  input  logic [WORD_BITS-1:0] right_i,
  output logic [WORD_BITS-1:0] value_o
);
  import cst_pkg::*;

  localparam logic [PosBits-1:0] MyPos = PosBits'(INDEX);

  logic [WORD_BITS-1:0] value_q;
  logic [WORD_BITS-1:0] value_d;

  always_comb begin
    value_d = value_q;
    case (ctrl_i.mode)
      CELL_OPEN: begin
        if (MyPos > ctrl_i.pos) begin
          value_d = left_i;
        end else if (MyPos == ctrl_i.pos) begin
          value_d = load_word_i;
        end
      end
      CELL_CLOSE: begin
        if (MyPos >= ctrl_i.pos) begin
          value_d = right_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

### rtl/cursor_sequence_table.sv
// Top level of the cursor sequence table: control, cell row and output register.
//
// Usage: an ordered list of up to DEPTH words with a cursor. Each input item
// carries an action (start, advance, insert before, attach after, remove, read)
// and a word for insert and attach. Every accepted item yields exactly one
// result item with the refusal flag, whether a current entry exists, the word
// under the cursor and the entry count.
// Channels: valid and stall on both sides; an item moves at a rising edge
// with valid high and stall low.
// Latency: the result is valid in the cycle after the item is accepted.
// Throughput: one item per cycle while the output is not stalled; each cell of the
// row shifts, loads or holds; insert and attach show the new word, start reads row
// zero, advance and remove read at the cursor's successor, read keeps the word.
// Stall: a held result stays in the output register; a new item is taken in
// the same cycle the held result leaves, so the input stalls only while the
// output register is full and stalled.
// Reset: count and cursor clear, the list is empty, no result is pending.
module cursor_sequence_table #(
  parameter int unsigned DEPTH     = cst_pkg::DepthDef,
  parameter int unsigned WORD_BITS = cst_pkg::WordBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cst_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cst_pkg::out_item_t out_item_o
);
  import cst_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);
  localparam logic [CW-1:0] Full = CW'(DEPTH);

  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        cursor_q, cursor_d;
  logic [WORD_BITS-1:0] cur_q, cur_d;
  logic                 out_valid_q;
  out_item_t            out_q, out_d;

  logic                 accept;
  logic                 has;
  logic                 full;
  logic                 refused;
  logic                 use_rd;
  logic [CW-1:0]        rd_idx;
  logic [WORD_BITS-1:0] rd_word;
  logic [WORD_BITS-1:0] new_word;
  logic                 has_d;
  cell_ctrl_t           ctrl;
  logic [WORD_BITS-1:0] row [DEPTH];

  assign accept   = in_valid_i && !in_stall_o;
  assign new_word = in_item_i.entry_value[WORD_BITS-1:0];
  assign has      = cursor_q < count_q;
  assign full     = count_q == Full;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] left_w;
    logic [WORD_BITS-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = row[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = row[i+1];
    end
    cst_cell #(
      .WORD_BITS(WORD_BITS),
      .INDEX    (i)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .load_word_i(new_word),
      .left_i     (left_w),
      .right_i    (right_w),
      .value_o    (row[i])
    );
  end

  assign rd_word = (rd_idx < Full) ? row[rd_idx[IW-1:0]] : '0;

  always_comb begin
    cursor_d  = cursor_q;
    count_d   = count_q;
    ctrl.mode = CELL_HOLD;
    ctrl.pos  = '0;
    refused   = 1'b0;
    use_rd    = 1'b0;
    rd_idx    = cursor_q + CW'(1);
    cur_d     = cur_q;
    case (action_e'(in_item_i.action))
      ACT_START: begin
        cursor_d = '0;
        rd_idx   = '0;
        use_rd   = 1'b1;
      end
      ACT_ADVANCE: begin
        if (has) begin
          cursor_d = cursor_q + CW'(1);
          use_rd   = 1'b1;
        end
      end
      ACT_INSERT: begin
        if (full) begin
          refused = 1'b1;
        end else begin
          cursor_d  = has ? cursor_q : '0;
          ctrl.mode = CELL_OPEN;
          ctrl.pos  = PosBits'(cursor_d);
          count_d   = count_q + CW'(1);
          cur_d     = new_word;
        end
      end
      ACT_ATTACH: begin
        if (full) begin
          refused = 1'b1;
        end else begin
          cursor_d  = has ? cursor_q + CW'(1) : count_q;
          ctrl.mode = CELL_OPEN;
          ctrl.pos  = PosBits'(cursor_d);
          count_d   = count_q + CW'(1);
          cur_d     = new_word;
        end
      end
      ACT_REMOVE: begin
        if (!has) begin
          refused = 1'b1;
        end else begin
          ctrl.mode = CELL_CLOSE;
          ctrl.pos  = PosBits'(cursor_q);
          count_d   = count_q - CW'(1);
          use_rd    = 1'b1;
        end
      end
      default: cur_d = cur_q;
    endcase
    if (use_rd) begin
      cur_d = rd_word;
    end
    if (!accept) begin
      ctrl.mode = CELL_HOLD;
    end
    has_d                = cursor_d < count_d;
    out_d.refused        = refused;
    out_d.has_current    = has_d;
    out_d.current_word   = has_d ? FieldBits'(cur_d) : '0;
    out_d.item_count     = CountBits'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q  <= count_d;
        cursor_q <= cursor_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q <= cur_d;
      out_q <= out_d;
    end
  end

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("entry count exceeds depth");

  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= count_q)
    else $error("cursor beyond entry count");

  a_refused_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && refused |=> $stable(count_q) && $stable(cursor_q))
    else $error("refused item changed the list");

  a_empty_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.has_current |-> out_item_o.current_word == '0)
    else $error("word shown without a current entry");

endmodule

### sim/tb_cursor_sequence_table.sv
// Self-checking testbench for the cursor sequence table, with a cycle-free list predictor.
module tb_cursor_sequence_table;
  timeunit 1ns;
  timeprecision 1ps;

  import cst_pkg::*;

  localparam int unsigned TableDepth = DepthDef;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned PrintLimit = 60;
  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam logic [FieldBits-1:0] WordOnes = '1;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  logic [FieldBits-1:0] list_words [TableDepth];
  int unsigned          list_count = 0;
  int unsigned          list_cursor = 0;
  out_item_t            cursor_views [$];
  int unsigned          mismatches = 0;
  int unsigned          quiet_cycles = 0;
  bit                   calm_phase = 1'b0;

  cursor_sequence_table DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always #1 clk_i = ~clk_i;

  always begin
    repeat (calm_phase ? $urandom_range(30, 120) : $urandom_range(100, 500)) @(posedge clk_i);
    calm_phase <= ~calm_phase;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic int unsigned draw_wait();
    if (calm_phase) begin
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  function automatic logic [FieldBits-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return WordOnes;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic out_item_t apply_action(input in_item_t item);
    out_item_t   res;
    logic        refused;
    int unsigned pos;
    int unsigned i;
    refused = 1'b0;
    case (item.action)
      ACT_START: list_cursor = 0;
      ACT_ADVANCE: begin
        if (list_cursor < list_count) list_cursor++;
      end
      ACT_INSERT, ACT_ATTACH: begin
        if (list_count >= TableDepth) begin
          refused = 1'b1;
        end else begin
          if (item.action == ACT_INSERT) begin
            pos = (list_cursor < list_count) ? list_cursor : 0;
          end else begin
            pos = (list_cursor < list_count) ? list_cursor + 1 : list_count;
          end
          for (i = list_count; i > pos; i--) list_words[i] = list_words[i-1];
          list_words[pos] = item.entry_value;
          list_cursor = pos;
          list_count++;
        end
      end
      ACT_REMOVE: begin
        if (list_cursor >= list_count) begin
          refused = 1'b1;
        end else begin
          for (i = list_cursor + 1; i < list_count; i++) list_words[i-1] = list_words[i];
          list_count--;
        end
      end
      default: ;
    endcase
    res.refused      = refused;
    res.has_current  = list_cursor < list_count;
    res.current_word = res.has_current ? list_words[list_cursor] : '0;
    res.item_count   = list_count[CountBits-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [FieldBits-1:0] got,
                                 input logic [FieldBits-1:0] want);
    mismatches++;
    if (mismatches <= PrintLimit) begin
      $display("%0t mismatch in %s: got %h, expected %h", $realtime, what, got, want);
    end
  endtask

  task automatic send_item(input logic [2:0] act, input logic [FieldBits-1:0] word);
    int unsigned gap;
    in_item_t    item;
    gap = draw_wait();
    item.action      = act;
    item.entry_value = word;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    cursor_views.push_back(apply_action(item));
  endtask

  initial begin : take_results
    int unsigned wait_cycles;
    out_item_t   want;
    wait (rst_ni === 1'b1);
    forever begin
      wait_cycles = draw_wait();
      if (wait_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      if (cursor_views.size() == 0) begin
        report_mismatch("unexpected result", out_item_o.current_word, '0);
      end else begin
        want = cursor_views.pop_front();
        if (out_item_o.refused !== want.refused)
          report_mismatch("refused", FieldBits'(out_item_o.refused),
                          FieldBits'(want.refused));
        if (out_item_o.has_current !== want.has_current)
          report_mismatch("has_current", FieldBits'(out_item_o.has_current),
                          FieldBits'(want.has_current));
        if (out_item_o.current_word !== want.current_word)
          report_mismatch("current_word", out_item_o.current_word, want.current_word);
        if (out_item_o.item_count !== want.item_count)
          report_mismatch("item_count", FieldBits'(out_item_o.item_count),
                          FieldBits'(want.item_count));
      end
    end
  end

  task automatic test_empty_list();
    send_item(ACT_READ, WordOnes);
    send_item(ACT_ADVANCE, WordOnes);
    send_item(ACT_REMOVE, WordOnes);
    send_item(ACT_START, WordOnes);
    send_item(ACT_SPARE_LO, WordOnes);
    send_item(ACT_SPARE_HI, WordOnes);
  endtask

  task automatic test_edit_cases();
    send_item(ACT_INSERT, WordOnes);
    send_item(ACT_INSERT, '0);
    send_item(ACT_ATTACH, 64'h0123_4567_89ab_cdef);
    send_item(ACT_ADVANCE, '0);
    send_item(ACT_ADVANCE, '0);
    send_item(ACT_ADVANCE, '0);
    send_item(ACT_INSERT, 64'h8000_0000_0000_0001);
    send_item(ACT_START, '0);
    send_item(ACT_ADVANCE, '0);
    send_item(ACT_ADVANCE, '0);
    send_item(ACT_ADVANCE, '0);
    send_item(ACT_ADVANCE, '0);
    send_item(ACT_ATTACH, 64'ha5a5_5a5a_f0f0_0f0f);
    send_item(ACT_REMOVE, '0);
    send_item(ACT_START, '0);
    send_item(ACT_REMOVE, '0);
    send_item(ACT_READ, '0);
  endtask

  task automatic test_fill_and_drain();
    repeat (4) begin
      while (list_count < TableDepth) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: send_item(ACT_INSERT, rand_word());
          4, 5, 6:    send_item(ACT_ATTACH, rand_word());
          7:          send_item(ACT_ADVANCE, rand_word());
          8:          send_item(ACT_START, rand_word());
          default:    send_item(ACT_READ, rand_word());
        endcase
      end
      repeat ($urandom_range(2, 4)) begin
        send_item($urandom_range(0, 1) ? ACT_INSERT : ACT_ATTACH, rand_word());
        if ($urandom_range(0, 1)) send_item(ACT_ADVANCE, rand_word());
      end
      while (list_count > 0) begin
        if (list_cursor >= list_count && $urandom_range(0, 1)) begin
          send_item(ACT_START, rand_word());
        end else begin
          case ($urandom_range(0, 7))
            0:       send_item(ACT_ADVANCE, rand_word());
            1:       send_item(ACT_READ, rand_word());
            default: send_item(ACT_REMOVE, rand_word());
          endcase
        end
      end
      send_item(ACT_REMOVE, rand_word());
    end
  endtask

  task automatic test_random_mix();
    repeat (580) send_item(3'($urandom_range(0, 7)), rand_word());
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_list();
    test_edit_cases();
    test_fill_and_drain();
    test_random_mix();
    in_valid_i <= 1'b0;
    while (cursor_views.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
